FILE: hw/rtl/tpld_pkg.sv
package tpld_pkg;

	localparam int RES_W       = 16;
	localparam int MODE_W      = 2;
	localparam int COLOR_W     = 8;
	localparam int PIXX_W      = 10;
	localparam int PIXY_W      = 16;
	localparam int PIX_W       = 3 * RES_W;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_W_W     = 11;
	localparam int CFG_H_W     = 16;
	localparam int WIDTH_LIMIT = 2 ** CFG_W_W - 1;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_TILE_SIZE  = 8;
	localparam int DEF_STORE_ROWS = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFG_W_W-1:0] WIDTH_RST  = 11'd1024;
	localparam logic [CFG_H_W-1:0] HEIGHT_RST = 16'd1024;

	localparam logic [MODE_W-1:0] MODE_MED  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_AVG  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_GRAD = 2'd2;
	localparam logic [MODE_W-1:0] MODE_LEFT = 2'd3;

	localparam logic [RES_W-1:0] LUMA_DEFAULT   = 16'd128;
	localparam logic [RES_W-1:0] CHROMA_DEFAULT = 16'd0;
	localparam logic [COLOR_W-1:0] COLOR_MAX    = 8'd255;

	// Per-pixel scan information handed from the sequencer to the datapath.
	typedef struct packed {
		logic [PIXY_W-1:0] y;
		logic              has_l;
		logic              has_t;
		logic              has_tl;
		logic              l_prev;
		logic              side_wr;
		logic              last;
	} scan_t;

	typedef struct packed {
		logic [PIXX_W-1:0] pixel_x;
		logic [PIXY_W-1:0] pixel_y;
		logic              last_pixel;
	} pix_meta_t;

endpackage

FILE: hw/rtl/tpld_if.sv
interface tpld_res_if import tpld_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RES_W-1:0]  y_residual;
	logic [RES_W-1:0]  cg_residual;
	logic [RES_W-1:0]  co_residual;
	logic [MODE_W-1:0] mode;

	modport source(output valid, output y_residual, output cg_residual, output co_residual,
		output mode, input ready);
	modport sink(input valid, input y_residual, input cg_residual, input co_residual,
		input mode, output ready);
endinterface

interface tpld_pix_if import tpld_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	logic [PIXX_W-1:0]  pixel_x;
	logic [PIXY_W-1:0]  pixel_y;
	logic               last_pixel;

	modport source(output valid, output red, output green, output blue, output pixel_x,
		output pixel_y, output last_pixel, input ready);
	modport sink(input valid, input red, input green, input blue, input pixel_x,
		input pixel_y, input last_pixel, output ready);
endinterface

FILE: hw/rtl/tile_predictive_lossless_decoder.sv
// Channel    Role    Handshake      Payload
// residuals  sink    valid/ready    y_residual, cg_residual, co_residual, mode
// pixels     source  valid/ready    red, green, blue, pixel_x, pixel_y, last_pixel
// cfg        write   cfg_we         cfg_index, cfg_data (no read-back)
//
// One pixel per clock cycle sustained while the output is not stalled; a result passes through
// stage one, stage two, stage three and the output register. The rate is set by the stage-one loop: left neighbour,
// prediction, residual add and the write-back register that feeds the next pixel.
// Reset clears the scan position and all stage valids and sets the size registers to
// 1024 x 1024; the row store is not cleared and needs no clearing pass.
// Ready falls only when every stage is full and the output transaction is not taken.
module tile_predictive_lossless_decoder import tpld_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int TILE_SIZE  = DEF_TILE_SIZE,
	parameter int STORE_ROWS = DEF_STORE_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tpld_res_if.sink              residuals,
	tpld_pix_if.source            pixels
);

	localparam int W_CAP = (MAX_WIDTH < WIDTH_LIMIT) ? MAX_WIDTH : WIDTH_LIMIT;
	localparam int XW    = $clog2(W_CAP);
	localparam int DEPTH = STORE_ROWS * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int EW    = $clog2(TILE_SIZE);

	// Handshake
	logic accept;
	logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
	logic s1_free, s2_free, s3_free, out_free;
	logic s1_adv, s2_adv, s3_adv;

	// Scan
	scan_t         scan_info;
	logic [XW-1:0] scan_x;
	logic [AW-1:0] scan_wr_addr;
	logic [AW-1:0] scan_t_addr;
	logic [AW-1:0] scan_tl_addr;
	logic [EW-1:0] scan_side_idx;

	// Stage one
	logic [PIX_W-1:0]  res_s1;
	logic [MODE_W-1:0] mode_s1;
	scan_t             info_s1;
	logic [XW-1:0]     x_s1;
	logic [AW-1:0]     wr_addr_s1;
	logic [AW-1:0]     t_addr_s1;
	logic [AW-1:0]     tl_addr_s1;
	logic [EW-1:0]     side_idx_s1;
	logic [PIX_W-1:0]  side_s1;
	logic [PIX_W-1:0]  mem_t_q;
	logic [PIX_W-1:0]  mem_tl_q;
	logic [PIX_W-1:0]  t_pix, tl_pix, l_pix, recon_pix;

	// Last pixel written to the store, forwarded to the next pixel.
	logic              last_wr_vld_q;
	logic [AW-1:0]     last_wr_addr_q;
	logic [PIX_W-1:0]  last_wr_data_q;

	logic [PIX_W-1:0]  store_mem [DEPTH];
	logic [PIX_W-1:0]  side_q [TILE_SIZE];

	pix_meta_t          meta_s2, meta_s3, meta_q;
	logic [COLOR_W-1:0] red_c, green_c, blue_c;
	logic [COLOR_W-1:0] red_q, green_q, blue_q;

	function automatic logic [RES_W-1:0] unzig(input logic [RES_W-1:0] v);
		logic [RES_W-1:0] h;
		h = {1'b0, v[RES_W-1:1]};
		return v[0] ? ~h : h;
	endfunction

	function automatic logic [RES_W-1:0] predict(input logic [MODE_W-1:0] m,
		input logic [RES_W-1:0] l, input logic [RES_W-1:0] t, input logic [RES_W-1:0] tl);
		logic signed [RES_W-1:0] ls, ts, tls, hi, lo;
		logic [RES_W-1:0]        grad;
		logic [RES_W:0]          sum;
		logic [RES_W-1:0]        p;
		ls   = $signed(l);
		ts   = $signed(t);
		tls  = $signed(tl);
		hi   = (ls > ts) ? ls : ts;
		lo   = (ls < ts) ? ls : ts;
		grad = l + t - tl;
		sum  = {l[RES_W-1], l} + {t[RES_W-1], t};
		case (m)
			MODE_MED: begin
				if (tls >= hi) begin
					p = lo;
				end else if (tls <= lo) begin
					p = hi;
				end else begin
					p = grad;
				end
			end
			MODE_AVG: begin
				p = sum[RES_W:1];
			end
			MODE_GRAD: begin
				p = grad;
			end
			MODE_LEFT: begin
				p = l;
			end
			default: begin
				p = l;
			end
		endcase
		return p;
	endfunction

	assign out_free = !out_v_q || pixels.ready;
	assign s3_adv   = s3_v_q && out_free;
	assign s3_free  = !s3_v_q || out_free;
	assign s2_adv   = s2_v_q && s3_free;
	assign s2_free  = !s2_v_q || s3_free;
	assign s1_adv   = s1_v_q && s2_free;
	assign s1_free  = !s1_v_q || s2_free;
	assign accept   = residuals.valid && s1_free;
	assign residuals.ready = s1_free;

	tpld_scan #(
		.MAX_WIDTH (MAX_WIDTH),
		.TILE_SIZE (TILE_SIZE),
		.STORE_ROWS(STORE_ROWS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.advance  (accept),
		.info     (scan_info),
		.x        (scan_x),
		.wr_addr  (scan_wr_addr),
		.t_addr   (scan_t_addr),
		.tl_addr  (scan_tl_addr),
		.side_idx (scan_side_idx)
	);

	// Row store: the pixel leaving stage one is written while the next pixel's
	// top neighbours are read; that read sees old data, so the one write just
	// made is forwarded from last_wr_*.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			store_mem[wr_addr_s1] <= recon_pix;
		end
		if (accept) begin
			mem_t_q  <= store_mem[scan_t_addr];
			mem_tl_q <= store_mem[scan_tl_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q        <= 1'b0;
			s2_v_q        <= 1'b0;
			s3_v_q        <= 1'b0;
			out_v_q       <= 1'b0;
			last_wr_vld_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_v_q <= accept;
			end
			if (s2_free) begin
				s2_v_q <= s1_adv;
			end
			if (s3_free) begin
				s3_v_q <= s2_adv;
			end
			if (out_free) begin
				out_v_q <= s3_adv;
			end
			if (s1_adv) begin
				last_wr_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1      <= {residuals.co_residual, residuals.cg_residual, residuals.y_residual};
			mode_s1     <= residuals.mode;
			info_s1     <= scan_info;
			x_s1        <= scan_x;
			wr_addr_s1  <= scan_wr_addr;
			t_addr_s1   <= scan_t_addr;
			tl_addr_s1  <= scan_tl_addr;
			side_idx_s1 <= scan_side_idx;
			side_s1     <= side_q[scan_side_idx];
		end
		if (s1_adv) begin
			last_wr_addr_q <= wr_addr_s1;
			last_wr_data_q <= recon_pix;
			if (info_s1.side_wr) begin
				side_q[side_idx_s1] <= recon_pix;
			end
			meta_s2.pixel_x    <= PIXX_W'(x_s1);
			meta_s2.pixel_y    <= info_s1.y;
			meta_s2.last_pixel <= info_s1.last;
		end
		if (s2_adv) begin
			meta_s3 <= meta_s2;
		end
		if (s3_adv) begin
			meta_q  <= meta_s3;
			red_q   <= red_c;
			green_q <= green_c;
			blue_q  <= blue_c;
		end
	end

	always_comb begin
		logic [RES_W-1:0] dflt, l, t, tl;
		t_pix  = (last_wr_vld_q && (last_wr_addr_q == t_addr_s1)) ? last_wr_data_q : mem_t_q;
		tl_pix = (last_wr_vld_q && (last_wr_addr_q == tl_addr_s1)) ? last_wr_data_q : mem_tl_q;
		l_pix  = info_s1.l_prev ? last_wr_data_q : side_s1;
		for (int c = 0; c < 3; c++) begin
			dflt = (c == 0) ? LUMA_DEFAULT : CHROMA_DEFAULT;
			l    = info_s1.has_l  ? l_pix[c*RES_W +: RES_W]  : dflt;
			t    = info_s1.has_t  ? t_pix[c*RES_W +: RES_W]  : dflt;
			tl   = info_s1.has_tl ? tl_pix[c*RES_W +: RES_W] : dflt;
			recon_pix[c*RES_W +: RES_W] = unzig(res_s1[c*RES_W +: RES_W]) + predict(mode_s1, l, t, tl);
		end
	end

	tpld_color u_color (
		.clk  (clk),
		.en_s2(s1_adv),
		.en_s3(s2_adv),
		.ycc  (recon_pix),
		.red  (red_c),
		.green(green_c),
		.blue (blue_c)
	);

	assign pixels.valid      = out_v_q;
	assign pixels.red        = red_q;
	assign pixels.green      = green_q;
	assign pixels.blue       = blue_q;
	assign pixels.pixel_x    = meta_q.pixel_x;
	assign pixels.pixel_y    = meta_q.pixel_y;
	assign pixels.last_pixel = meta_q.last_pixel;

	// After the final pixel of an image the scan is back at the origin.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && scan_info.last |=> (scan_x == '0) && (scan_info.y == '0))
		else $error("scan did not restart after the last pixel");

	// A left neighbour taken from the forwarding register is the pixel just left of this one.
	a_left_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && info_s1.has_l && info_s1.l_prev |->
		last_wr_vld_q && (last_wr_addr_q == (wr_addr_s1 - AW'(1))))
		else $error("forwarded left neighbour is not the adjacent pixel");

	// A stalled stage-one pixel keeps its slot and its store address.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && !s1_adv |=> s1_v_q && $stable(wr_addr_s1) && $stable(last_wr_addr_q))
		else $error("stage one changed while stalled");

endmodule

FILE: hw/rtl/tpld_scan.sv
module tpld_scan import tpld_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int TILE_SIZE  = DEF_TILE_SIZE,
	parameter int STORE_ROWS = DEF_STORE_ROWS,
	localparam int W_CAP = (MAX_WIDTH < WIDTH_LIMIT) ? MAX_WIDTH : WIDTH_LIMIT,
	localparam int XW    = $clog2(W_CAP),
	localparam int AW    = $clog2(STORE_ROWS * MAX_WIDTH),
	localparam int EW    = $clog2(TILE_SIZE)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  advance,
	output scan_t                 info,
	output logic [XW-1:0]         x,
	output logic [AW-1:0]         wr_addr,
	output logic [AW-1:0]         t_addr,
	output logic [AW-1:0]         tl_addr,
	output logic [EW-1:0]         side_idx
);

	localparam int WW  = $clog2(W_CAP + 1);
	localparam int EXW = $clog2(W_CAP + TILE_SIZE + 1);
	localparam int RW  = $clog2(STORE_ROWS);
	localparam int YEW = PIXY_W + 1;

	logic [CFG_W_W-1:0] width_q;
	logic [CFG_H_W-1:0] height_q;
	logic [XW-1:0]      x_q;
	logic [XW-1:0]      col0_q;
	logic [PIXY_W-1:0]  y_q;
	logic [PIXY_W-1:0]  row0_q;
	logic [RW-1:0]      row_q;
	logic [RW-1:0]      row0_idx_q;

	logic [WW-1:0]      eff_w;
	logic [CFG_H_W-1:0] eff_h;
	logic [EXW-1:0]     xe_full;
	logic [EXW-1:0]     xe;
	logic [EXW-1:0]     x1;
	logic [YEW-1:0]     ye_full;
	logic [YEW-1:0]     ye;
	logic [YEW-1:0]     y1;
	logic               step_col;
	logic               step_row;
	logic               step_tile;
	logic               step_band;
	logic               tile_h_one;
	logic [RW-1:0]      row_next;
	logic [RW-1:0]      row_prev;
	logic [AW-1:0]      row_base;
	logic [AW-1:0]      prev_base;

	always_comb begin
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (width_q > CFG_W_W'(W_CAP)) begin
			eff_w = WW'(W_CAP);
		end else begin
			eff_w = WW'(width_q);
		end
		eff_h = (height_q == '0) ? CFG_H_W'(1) : height_q;

		xe_full = EXW'(col0_q) + EXW'(TILE_SIZE);
		xe      = (xe_full > EXW'(eff_w)) ? EXW'(eff_w) : xe_full;
		x1      = EXW'(x_q) + EXW'(1);
		ye_full = YEW'(row0_q) + YEW'(TILE_SIZE);
		ye      = (ye_full > YEW'(eff_h)) ? YEW'(eff_h) : ye_full;
		y1      = YEW'(y_q) + YEW'(1);

		step_col   = x1 < xe;
		step_row   = y1 < ye;
		step_tile  = xe < EXW'(eff_w);
		step_band  = ye < YEW'(eff_h);
		tile_h_one = ye == (YEW'(row0_q) + YEW'(1));

		row_next = (row_q == RW'(STORE_ROWS - 1)) ? '0 : row_q + RW'(1);
		row_prev = (row_q == '0) ? RW'(STORE_ROWS - 1) : row_q - RW'(1);
		row_base  = AW'(row_q) * AW'(MAX_WIDTH);
		prev_base = AW'(row_prev) * AW'(MAX_WIDTH);
	end

	assign x        = x_q;
	assign wr_addr  = row_base + AW'(x_q);
	assign t_addr   = prev_base + AW'(x_q);
	assign tl_addr  = prev_base + AW'(x_q) - AW'(1);
	assign side_idx = EW'(y_q - row0_q);

	// The left neighbour is the previous pixel in scan order except on the
	// first column of a tile taller than one row, where it comes from the
	// column saved from the tile to the left.
	always_comb begin
		info.y       = y_q;
		info.has_l   = x_q != '0;
		info.has_t   = y_q != '0;
		info.has_tl  = (x_q != '0) && (y_q != '0);
		info.l_prev  = (x_q != col0_q) || tile_h_one;
		info.side_wr = !step_col;
		info.last    = !step_col && !step_row && !step_tile && !step_band;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
			x_q        <= '0;
			col0_q     <= '0;
			y_q        <= '0;
			row0_q     <= '0;
			row_q      <= '0;
			row0_idx_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[CFG_W_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[CFG_H_W-1:0];
				end
				default: begin
				end
			endcase
			x_q        <= '0;
			col0_q     <= '0;
			y_q        <= '0;
			row0_q     <= '0;
			row_q      <= '0;
			row0_idx_q <= '0;
		end else if (advance) begin
			if (step_col) begin
				x_q <= x_q + XW'(1);
			end else if (step_row) begin
				x_q   <= col0_q;
				y_q   <= y_q + PIXY_W'(1);
				row_q <= row_next;
			end else if (step_tile) begin
				col0_q <= XW'(xe);
				x_q    <= XW'(xe);
				y_q    <= row0_q;
				row_q  <= row0_idx_q;
			end else if (step_band) begin
				col0_q     <= '0;
				x_q        <= '0;
				row0_q     <= PIXY_W'(ye);
				y_q        <= PIXY_W'(ye);
				row_q      <= row_next;
				row0_idx_q <= row_next;
			end else begin
				x_q        <= '0;
				col0_q     <= '0;
				y_q        <= '0;
				row0_q     <= '0;
				row_q      <= '0;
				row0_idx_q <= '0;
			end
		end
	end

endmodule

FILE: hw/rtl/tpld_color.sv
module tpld_color import tpld_pkg::*; (
	input  logic               clk,
	input  logic               en_s2,
	input  logic               en_s3,
	input  logic [PIX_W-1:0]   ycc,
	output logic [COLOR_W-1:0] red,
	output logic [COLOR_W-1:0] green,
	output logic [COLOR_W-1:0] blue
);

	localparam int VW = RES_W + 3;
	localparam logic signed [VW-1:0] CLAMP_HI = VW'(COLOR_MAX);

	logic signed [RES_W-1:0]   y_s2;
	logic signed [RES_W-1:0]   cg_s2;
	logic signed [RES_W-1:0]   co_s2;
	logic signed [RES_W:0]     t_s3;
	logic signed [RES_W-1:0]   cg_s3;
	logic signed [RES_W-1:0]   co_s3;
	logic signed [RES_W:0]     t_c;
	logic signed [RES_W+1:0]   g_c;
	logic signed [RES_W+1:0]   b_c;
	logic signed [VW-1:0]      r_c;

	function automatic logic [COLOR_W-1:0] clamp8(input logic signed [VW-1:0] v);
		logic [COLOR_W-1:0] c;
		if (v < 0) begin
			c = '0;
		end else if (v > CLAMP_HI) begin
			c = COLOR_MAX;
		end else begin
			c = v[COLOR_W-1:0];
		end
		return c;
	endfunction

	always_ff @(posedge clk) begin
		if (en_s2) begin
			y_s2  <= $signed(ycc[RES_W-1:0]);
			cg_s2 <= $signed(ycc[2*RES_W-1:RES_W]);
			co_s2 <= $signed(ycc[3*RES_W-1:2*RES_W]);
		end
		if (en_s3) begin
			t_s3  <= t_c;
			cg_s3 <= cg_s2;
			co_s3 <= co_s2;
		end
	end

	// Inverse YCgCo-R; arithmetic shifts give the floor halving.
	always_comb begin
		t_c = (RES_W+1)'(y_s2) - (RES_W+1)'(cg_s2 >>> 1);
		g_c = (RES_W+2)'(cg_s3) + (RES_W+2)'(t_s3);
		b_c = (RES_W+2)'(t_s3) - (RES_W+2)'(co_s3 >>> 1);
		r_c = VW'(b_c) + VW'(co_s3);
	end

	assign red   = clamp8(r_c);
	assign green = clamp8(VW'(g_c));
	assign blue  = clamp8(VW'(b_c));

endmodule
